// ===== rtl/vpsd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the video playout sync decider.
// Holds the field widths, the action and decision codes and the shared item/result types.
package vpsd_pkg;

    localparam int TS_W      = 64;
    localparam int SEQ_W     = 64;
    localparam int NOW_W     = 48;
    localparam int LIMIT_W   = 16;
    localparam int ACT_W     = 2;
    localparam int DEC_W     = 2;
    localparam int POPCNT_W  = 9;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd400;
    localparam logic [SEQ_W-1:0]   NO_SEQ      = {SEQ_W{1'b1}};

    typedef enum logic [ACT_W-1:0] {
        ACT_AUDIO_POP = 2'd0,
        ACT_VIDEO_POP = 2'd1,
        ACT_FRAME     = 2'd2,
        ACT_QUERY     = 2'd3
    } action_t;

    typedef enum logic [DEC_W-1:0] {
        DEC_HOLD       = 2'd0,
        DEC_POP        = 2'd1,
        DEC_DISCARD    = 2'd2,
        DEC_VIDEO_ONLY = 2'd3
    } decision_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [TS_W-1:0]  time_stamp;
        logic [SEQ_W-1:0] seq_number;
        logic [NOW_W-1:0] now_ms;
        logic             is_key_frame;
        logic             first_in_scan;
        logic             last_in_scan;
    } item_t;

    typedef struct packed {
        decision_t           decision;
        logic [POPCNT_W-1:0] pop_count;
    } result_t;

endpackage

// ===== rtl/video_playout_sync_decider_unit.sv =====
`timescale 1ns / 1ps
// Top level of the video playout sync decider: input register, decision core, result register.
// Depends on vpsd_pkg, vpsd_scan_core and vpsd_out_reg.

// One item per clock is accepted sustained. Each transfer is captured in an input
// register; once the result register is free, the decision core evaluates it against
// the stored audio and video state and the running scan, updates that state, and, for
// an empty-queue query or the last frame of a scan, loads the result register, which
// drives out_valid. Audio and video pop events and frames not marked last update
// state and produce no result. The input side only stalls while the input register
// holds an item and the result register is full and not being drained. pop_count
// saturates at MAX_SCAN and shows its low 9 bits. The stale limit register (reset
// 400 ms) is written through the cfg channel, which is always ready; write it only
// while no item is in flight.
module video_playout_sync_decider_unit #(
    parameter int MAX_SCAN = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input item channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [vpsd_pkg::ACT_W-1:0]    action,
    input  logic [vpsd_pkg::TS_W-1:0]     time_stamp,
    input  logic [vpsd_pkg::SEQ_W-1:0]    seq_number,
    input  logic [vpsd_pkg::NOW_W-1:0]    now_ms,
    input  logic                          is_key_frame,
    input  logic                          first_in_scan,
    input  logic                          last_in_scan,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vpsd_pkg::DEC_W-1:0]    decision,
    output logic [vpsd_pkg::POPCNT_W-1:0] pop_count,
    // stale limit write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vpsd_pkg::LIMIT_W-1:0]  cfg_data
);

    logic              s1_valid_reg, s1_valid_next;
    vpsd_pkg::item_t   s1_item_reg;
    logic              in_xfer;
    logic              advance;
    logic              out_free;
    logic              res_valid;
    vpsd_pkg::result_t res;
    vpsd_pkg::result_t out_data;

    assign in_ready  = !s1_valid_reg || out_free;
    assign in_xfer   = in_valid && in_ready;
    // Held item is processed once the result register can take a result
    assign advance   = s1_valid_reg && out_free;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg.action        <= action;
            s1_item_reg.time_stamp    <= time_stamp;
            s1_item_reg.seq_number    <= seq_number;
            s1_item_reg.now_ms        <= now_ms;
            s1_item_reg.is_key_frame  <= is_key_frame;
            s1_item_reg.first_in_scan <= first_in_scan;
            s1_item_reg.last_in_scan  <= last_in_scan;
        end
    end

    vpsd_scan_core #(
        .MAX_SCAN (MAX_SCAN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (s1_item_reg),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    vpsd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .load_data (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (out_free),
        .data      (out_data)
    );

    assign decision  = out_data.decision;
    assign pop_count = out_data.pop_count;

endmodule

// ===== rtl/vpsd_scan_core.sv =====
`timescale 1ns / 1ps
// Sync state and per-item decision logic of the playout sync decider.
// Depends on vpsd_pkg for item/result types and codes.
module vpsd_scan_core #(
    parameter int MAX_SCAN = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  vpsd_pkg::item_t              item,
    input  logic                         cfg_we,
    input  logic [vpsd_pkg::LIMIT_W-1:0] cfg_data,
    output logic                         res_valid,
    output vpsd_pkg::result_t            res
);

    localparam int CNT_W  = $clog2(MAX_SCAN + 1);
    localparam int WIDE_W = CNT_W + vpsd_pkg::POPCNT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SCAN);

    logic [vpsd_pkg::LIMIT_W-1:0] limit_reg;
    logic [vpsd_pkg::TS_W-1:0]    audio_ts_reg, audio_ts_next;
    logic [vpsd_pkg::NOW_W-1:0]   audio_local_reg, audio_local_next;
    logic [vpsd_pkg::SEQ_W-1:0]   last_seq_reg, last_seq_next;
    vpsd_pkg::decision_t          dec_reg, dec_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         stop_reg, stop_next;

    // Scan state as seen by this frame, after a possible restart
    vpsd_pkg::decision_t          dec_base;
    logic [CNT_W-1:0]             cnt_base;
    logic [CNT_W-1:0]             cnt_up;
    logic                         stop_base;
    logic                         seq_match;
    logic                         audio_ahead;
    logic                         audio_stale;
    logic [vpsd_pkg::NOW_W-1:0]   elapsed;
    logic [WIDE_W-1:0]            cnt_wide;

    assign dec_base  = item.first_in_scan ? vpsd_pkg::DEC_HOLD : dec_reg;
    assign cnt_base  = item.first_in_scan ? '0 : cnt_reg;
    assign stop_base = item.first_in_scan ? 1'b0 : stop_reg;
    assign cnt_up    = (cnt_base < CNT_MAX) ? cnt_base + CNT_W'(1) : cnt_base;

    assign seq_match   = item.seq_number ==
                         (last_seq_reg + vpsd_pkg::SEQ_W'(cnt_base) + vpsd_pkg::SEQ_W'(1));
    assign audio_ahead = item.time_stamp < audio_ts_reg;
    assign elapsed     = item.now_ms - audio_local_reg;
    assign audio_stale = (item.now_ms > audio_local_reg) &&
                         (elapsed > vpsd_pkg::NOW_W'(limit_reg));

    always_comb
    begin
        audio_ts_next    = audio_ts_reg;
        audio_local_next = audio_local_reg;
        last_seq_next    = last_seq_reg;
        dec_next         = dec_reg;
        cnt_next         = cnt_reg;
        stop_next        = stop_reg;
        res_valid        = 1'b0;

        if (fire)
        begin
            case (vpsd_pkg::action_t'(item.action))
                vpsd_pkg::ACT_AUDIO_POP:
                begin
                    audio_ts_next    = item.time_stamp;
                    audio_local_next = item.now_ms;
                end
                vpsd_pkg::ACT_VIDEO_POP:
                begin
                    last_seq_next = item.seq_number;
                end
                vpsd_pkg::ACT_QUERY:
                begin
                    dec_next  = vpsd_pkg::DEC_HOLD;
                    cnt_next  = '0;
                    stop_next = 1'b0;
                    res_valid = 1'b1;
                end
                vpsd_pkg::ACT_FRAME:
                begin
                    dec_next  = dec_base;
                    cnt_next  = cnt_base;
                    stop_next = stop_base;
                    res_valid = item.last_in_scan;
                    if (!stop_base)
                    begin
                        // Key-frame seek applies with no video popped yet, or on a
                        // sequence gap outside a pop run
                        if ((last_seq_reg == vpsd_pkg::NO_SEQ) ||
                            (!seq_match && (dec_base != vpsd_pkg::DEC_POP)))
                        begin
                            if (!item.is_key_frame)
                            begin
                                dec_next = vpsd_pkg::DEC_DISCARD;
                                cnt_next = cnt_up;
                            end
                            else
                            begin
                                if (dec_base != vpsd_pkg::DEC_DISCARD)
                                begin
                                    dec_next = vpsd_pkg::DEC_POP;
                                    cnt_next = cnt_up;
                                end
                                stop_next = 1'b1;
                            end
                        end
                        else if (!seq_match)
                        begin
                            // gap after in-order pops ends the run
                            stop_next = 1'b1;
                        end
                        else if (audio_ts_reg == '0)
                        begin
                            dec_next = vpsd_pkg::DEC_VIDEO_ONLY;
                            cnt_next = cnt_up;
                        end
                        else if (audio_ahead)
                        begin
                            dec_next = vpsd_pkg::DEC_POP;
                            cnt_next = cnt_up;
                        end
                        else if (audio_stale)
                        begin
                            dec_next  = vpsd_pkg::DEC_VIDEO_ONLY;
                            cnt_next  = cnt_up;
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            stop_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    assign cnt_wide      = WIDE_W'(cnt_next);
    assign res.decision  = dec_next;
    assign res.pop_count = cnt_wide[vpsd_pkg::POPCNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg       <= vpsd_pkg::LIMIT_RESET;
            audio_ts_reg    <= '0;
            audio_local_reg <= '0;
            last_seq_reg    <= vpsd_pkg::NO_SEQ;
            dec_reg         <= vpsd_pkg::DEC_HOLD;
            cnt_reg         <= '0;
            stop_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            audio_ts_reg    <= audio_ts_next;
            audio_local_reg <= audio_local_next;
            last_seq_reg    <= last_seq_next;
            dec_reg         <= dec_next;
            cnt_reg         <= cnt_next;
            stop_reg        <= stop_next;
        end
    end

endmodule

// ===== rtl/vpsd_out_reg.sv =====
`timescale 1ns / 1ps
// Result register of the playout sync decider, holds one result until transferred.
// Depends on vpsd_pkg for the result type.
module vpsd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  vpsd_pkg::result_t load_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              free,
    output vpsd_pkg::result_t data
);

    logic              valid_reg, valid_next;
    vpsd_pkg::result_t data_reg, data_next;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign data      = data_reg;

endmodule

// ===== rtl/vpsd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the playout sync decider, bound to the top level.
// Depends on vpsd_pkg for codes and widths.
module vpsd_checker #(
    parameter int MAX_SCAN = 256
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [vpsd_pkg::DEC_W-1:0]    decision,
    input logic [vpsd_pkg::POPCNT_W-1:0] pop_count
);

    localparam bit CNT_FITS = (MAX_SCAN < (1 << vpsd_pkg::POPCNT_W));

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(decision) && $stable(pop_count))
        else $error("result changed while stalled");

    // hold never releases frames
    a_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (decision == vpsd_pkg::DEC_HOLD) |-> (pop_count == '0))
        else $error("hold decision with nonzero count");

    // when MAX_SCAN fits in pop_count, any release decision names at least one frame and stays within the limit
    a_release_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (decision != vpsd_pkg::DEC_HOLD) && CNT_FITS |->
            (pop_count != '0) && (pop_count <= vpsd_pkg::POPCNT_W'(MAX_SCAN)))
        else $error("release decision count out of range");

    // the input only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid)
        else $error("input stalled with no result held");

endmodule

bind video_playout_sync_decider_unit vpsd_checker #(
    .MAX_SCAN (MAX_SCAN)
) u_vpsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .decision  (decision),
    .pop_count (pop_count)
);
